[rtl/bpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric pressure compensation package
// Beat types, register indexes, compensation constants and the divider step.
// ----------------------------------------------------------------------------
package bpc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_error;
  } out_beat_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivSteps = 32;

  localparam logic [CfgIdxW-1:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_B1_B2   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MC_MD   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OSS     = 3'd5;

  localparam logic [1:0]  OSS_RESET = 2'd2;
  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] X3_BIAS   = 32'd32768;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] P_COEF_SQ = 32'd3038;
  localparam logic [31:0] P_COEF_LN = 32'hFFFF_E343;
  localparam logic [31:0] P_BIAS    = 32'd3791;

  // one restoring step: upper half remainder, lower half dividend/quotient
  function automatic logic [63:0] div_step(input logic [63:0] rq, input logic [31:0] d);
    logic [32:0] rem;
    logic [32:0] diff;
    logic [63:0] res;
    rem  = {rq[63:31]};
    diff = rem - {1'b0, d};
    if (!diff[32]) begin
      res = {diff[31:0], rq[30:0], 1'b1};
    end else begin
      res = {rem[31:0], rq[30:0], 1'b0};
    end
    return res;
  endfunction

endpackage

[rtl/barometric_pressure_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Fixed-point temperature and pressure compensation with two bit-per-stage
// pipelined dividers.
//
//   port group | dir | handshake        | beat
//   in_        | in  | in_valid/ready   | raw temperature, raw pressure
//   out_       | out | out_valid/ready  | temperature, pressure, error flag
//   cfg_       | in  | cfg_we           | calibration word or oversampling
//
// One beat enters per cycle while the output is not stalled; a beat passes 79
// register stages to out_valid, set mostly by the two 32-stage dividers.
// All stages advance together when the output register is empty or taken;
// a stalled output holds every stage.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bpc_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bpc_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  typedef struct packed {
    logic [63:0] rq;
    logic [31:0] d;
    logic        neg;
    logic        err;
    logic [31:0] x1;
    logic [23:0] up;
  } tdiv_t;

  typedef struct packed {
    logic [63:0] rq;
    logic [31:0] d;
    logic        hi;
    logic        err;
    logic [15:0] t;
  } pdiv_t;

  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;
  logic        adv;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac12_r[31]}}, ac12_r[31:16]};
  assign ac2 = {{16{ac12_r[15]}}, ac12_r[15:0]};
  assign ac3 = {{16{ac34_r[31]}}, ac34_r[31:16]};
  assign ac4 = {16'd0, ac34_r[15:0]};
  assign ac5 = {16'd0, ac56_r[31:16]};
  assign ac6 = {16'd0, ac56_r[15:0]};
  assign b1  = {{16{b12_r[31]}}, b12_r[31:16]};
  assign b2  = {{16{b12_r[15]}}, b12_r[15:0]};
  assign mc  = {{16{mcmd_r[31]}}, mcmd_r[31:16]};
  assign md  = {{16{mcmd_r[15]}}, mcmd_r[15:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= '0;
      ac34_r <= '0;
      ac56_r <= '0;
      b12_r  <= '0;
      mcmd_r <= '0;
      oss_r  <= bpc_pkg::OSS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_AC1_AC2: ac12_r <= cfg_wdata;
        bpc_pkg::CFG_AC3_AC4: ac34_r <= cfg_wdata;
        bpc_pkg::CFG_AC5_AC6: ac56_r <= cfg_wdata;
        bpc_pkg::CFG_B1_B2:   b12_r  <= cfg_wdata;
        bpc_pkg::CFG_MC_MD:   mcmd_r <= cfg_wdata;
        bpc_pkg::CFG_OSS:     oss_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage valid bits
  logic v0_r, v1_r, v2_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic v11_r, v12_r, v13_r, out_valid_r;
  logic [bpc_pkg::DivSteps:0] tv_r;
  logic [bpc_pkg::DivSteps:0] pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
      v11_r <= 1'b0; v12_r <= 1'b0; v13_r <= 1'b0; out_valid_r <= 1'b0;
      tv_r <= '0;
      pv_r <= '0;
    end else if (adv) begin
      v0_r  <= in_valid;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      tv_r  <= {tv_r[bpc_pkg::DivSteps-1:0], v2_r};
      v4_r  <= tv_r[bpc_pkg::DivSteps];
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      pv_r  <= {pv_r[bpc_pkg::DivSteps-1:0], v9_r};
      v11_r <= pv_r[bpc_pkg::DivSteps];
      v12_r <= v11_r;
      v13_r <= v12_r;
      out_valid_r <= v13_r;
    end
  end

  // temperature front end
  logic [31:0] ut0_r, up0_r, m1_r, up1_r, x1_2_r, den2_r, num2_r, up2_r;
  logic [31:0] ut_diff, m1_nxt, x1_nxt, den_nxt;
  assign ut_diff = ut0_r - ac6;
  assign m1_nxt  = ut_diff * ac5;
  assign x1_nxt  = $signed(m1_r) >>> 15;
  assign den_nxt = x1_nxt + md;

  always_ff @(posedge clk) begin
    if (adv) begin
      ut0_r  <= {16'd0, in_data.raw_temperature};
      up0_r  <= {8'd0, in_data.raw_pressure} >> (4'd8 - {2'd0, oss_r});
      m1_r   <= m1_nxt;
      up1_r  <= up0_r;
      x1_2_r <= x1_nxt;
      den2_r <= den_nxt;
      num2_r <= mc << 11;
      up2_r  <= up1_r;
    end
  end

  // temperature divider
  tdiv_t td_r [0:bpc_pkg::DivSteps];
  tdiv_t td_nxt [1:bpc_pkg::DivSteps];
  tdiv_t td_in;
  always_comb begin
    td_in.rq  = {32'd0, num2_r[31] ? -num2_r : num2_r};
    td_in.d   = den2_r[31] ? -den2_r : den2_r;
    td_in.neg = num2_r[31] ^ den2_r[31];
    td_in.err = (den2_r == 32'd0);
    td_in.x1  = x1_2_r;
    td_in.up  = up2_r[23:0];
  end

  always_comb begin
    for (int i = 1; i <= bpc_pkg::DivSteps; i++) begin
      td_nxt[i]    = td_r[i-1];
      td_nxt[i].rq = bpc_pkg::div_step(td_r[i-1].rq, td_r[i-1].d);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      td_r[0] <= td_in;
      for (int i = 1; i <= bpc_pkg::DivSteps; i++) begin
        td_r[i] <= td_nxt[i];
      end
    end
  end

  // b5, b6, products
  logic [31:0] b5_4_r, up4_r, b6_5_r, up5_r, up6_r, up7_r, up8_r;
  logic        err4_r, err5_r, err6_r, err7_r, err8_r, err9_r;
  logic [15:0] t5_r, t6_r, t7_r, t8_r, t9_r;
  logic [31:0] tq, t_full, tsat;
  logic [31:0] sq6_r, a2_6_r, a3_6_r, t1_7_r, t2_7_r, a2_7_r, a3_7_r;
  logic [31:0] b3_8_r, x3_8_r, b4_9_r, b7_9_r;
  logic [31:0] sq_nxt, a2_nxt, a3_nxt, t1_nxt, t2_nxt, x3a, b3_base, b3_nxt, x3_nxt;
  logic [31:0] b4_prod, b7_nxt, b7_diff;

  assign tq     = td_r[bpc_pkg::DivSteps].rq[31:0];
  assign t_full = $signed(b5_4_r + 32'd8) >>> 4;
  always_comb begin
    if ($signed(t_full) > 32'sd32767) begin
      tsat = 32'd32767;
    end else if ($signed(t_full) < -32'sd32768) begin
      tsat = 32'hFFFF_8000;
    end else begin
      tsat = t_full;
    end
  end

  assign sq_nxt  = $signed(b6_5_r * b6_5_r) >>> 12;
  assign a2_nxt  = $signed(ac2 * b6_5_r) >>> 11;
  assign a3_nxt  = $signed(ac3 * b6_5_r) >>> 13;
  assign t1_nxt  = $signed(b2 * sq6_r) >>> 11;
  assign t2_nxt  = $signed(b1 * sq6_r) >>> 16;
  assign x3a     = t1_7_r + a2_7_r;
  assign b3_base = ((ac1 << 2) + x3a) << oss_r;
  assign b3_nxt  = $signed(b3_base + 32'd2) >>> 2;
  assign x3_nxt  = $signed(a3_7_r + t2_7_r + 32'd2) >>> 2;
  assign b4_prod = ac4 * (x3_8_r + bpc_pkg::X3_BIAS);
  assign b7_diff = up8_r - b3_8_r;
  assign b7_nxt  = b7_diff * (bpc_pkg::B7_SCALE >> oss_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      b5_4_r <= td_r[bpc_pkg::DivSteps].x1 + (td_r[bpc_pkg::DivSteps].neg ? -tq : tq);
      up4_r  <= {8'd0, td_r[bpc_pkg::DivSteps].up};
      err4_r <= td_r[bpc_pkg::DivSteps].err;
      b6_5_r <= b5_4_r - bpc_pkg::B6_OFFSET;
      t5_r   <= tsat[15:0];
      up5_r  <= up4_r;
      err5_r <= err4_r;
      sq6_r  <= sq_nxt;
      a2_6_r <= a2_nxt;
      a3_6_r <= a3_nxt;
      t6_r   <= t5_r;
      up6_r  <= up5_r;
      err6_r <= err5_r;
      t1_7_r <= t1_nxt;
      t2_7_r <= t2_nxt;
      a2_7_r <= a2_6_r;
      a3_7_r <= a3_6_r;
      t7_r   <= t6_r;
      up7_r  <= up6_r;
      err7_r <= err6_r;
      b3_8_r <= b3_nxt;
      x3_8_r <= x3_nxt;
      t8_r   <= t7_r;
      up8_r  <= up7_r;
      err8_r <= err7_r;
      b4_9_r <= b4_prod >> 15;
      b7_9_r <= b7_nxt;
      t9_r   <= t8_r;
      err9_r <= err8_r;
    end
  end

  // pressure divider
  pdiv_t pd_r [0:bpc_pkg::DivSteps];
  pdiv_t pd_nxt [1:bpc_pkg::DivSteps];
  pdiv_t pd_in;
  always_comb begin
    pd_in.rq  = {32'd0, b7_9_r[31] ? b7_9_r : (b7_9_r << 1)};
    pd_in.d   = b4_9_r;
    pd_in.hi  = b7_9_r[31];
    pd_in.err = err9_r || (b4_9_r == 32'd0);
    pd_in.t   = t9_r;
  end

  always_comb begin
    for (int i = 1; i <= bpc_pkg::DivSteps; i++) begin
      pd_nxt[i]    = pd_r[i-1];
      pd_nxt[i].rq = bpc_pkg::div_step(pd_r[i-1].rq, pd_r[i-1].d);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pd_r[0] <= pd_in;
      for (int i = 1; i <= bpc_pkg::DivSteps; i++) begin
        pd_r[i] <= pd_nxt[i];
      end
    end
  end

  // pressure correction
  logic [31:0] pq, p11_r, p12_r, p13_r, sq12_r, x2_12_r, x2_13_r, x1_13_r;
  logic [31:0] ps, corr, p_fin;
  logic [15:0] t11_r, t12_r, t13_r;
  logic        err11_r, err12_r, err13_r;
  bpc_pkg::out_beat_t out_r;

  assign pq    = pd_r[bpc_pkg::DivSteps].rq[31:0];
  assign ps    = $signed(p11_r) >>> 8;
  assign corr  = $signed(x1_13_r + x2_13_r + bpc_pkg::P_BIAS) >>> 4;
  assign p_fin = p13_r + corr;

  always_ff @(posedge clk) begin
    if (adv) begin
      p11_r   <= pd_r[bpc_pkg::DivSteps].hi ? (pq << 1) : pq;
      t11_r   <= pd_r[bpc_pkg::DivSteps].t;
      err11_r <= pd_r[bpc_pkg::DivSteps].err;
      sq12_r  <= ps * ps;
      x2_12_r <= $signed(bpc_pkg::P_COEF_LN * p11_r) >>> 16;
      p12_r   <= p11_r;
      t12_r   <= t11_r;
      err12_r <= err11_r;
      x1_13_r <= $signed(sq12_r * bpc_pkg::P_COEF_SQ) >>> 16;
      x2_13_r <= x2_12_r;
      p13_r   <= p12_r;
      t13_r   <= t12_r;
      err13_r <= err12_r;
      out_r.temperature_tenths <= err13_r ? 16'sd0 : t13_r;
      out_r.pressure_pa        <= err13_r ? 32'sd0 : p_fin;
      out_r.divide_error       <= err13_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_error |->
      out_data.temperature_tenths == 16'sd0 && out_data.pressure_pa == 32'sd0)
    else $error("error beat carries non-zero fields");
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tv_r) && $stable(pv_r))
    else $error("divider stages moved during stall");
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v13_r))
    else $error("output valid without pipeline beat");
`endif

endmodule

[dv/barometric_pressure_compensation_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric pressure compensation testbench
// Drives raw temperature and pressure beats through the compensation pipeline
// under several calibration sets and idling mixes, and checks every result
// beat against an in-bench integer model of the datasheet compensation.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_test;

  localparam int unsigned Latency = 78;
  localparam longint unsigned CycleLimit = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bpc_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bpc_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [bpc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  bpc_pkg::in_beat_t pending_beats[$];
  bpc_pkg::out_beat_t expected_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;

  logic [31:0] cal_ac12, cal_ac34, cal_ac56, cal_b12, cal_mcmd;
  logic [1:0] cal_oss;

  barometric_pressure_compensation u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] sra(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
    longint q;
    q = longint'($signed(a)) / longint'($signed(b));
    return q[31:0];
  endfunction

  function automatic bpc_pkg::out_beat_t compensate(input bpc_pkg::in_beat_t beat);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, den, t;
    bpc_pkg::out_beat_t r;
    ac1 = sx16(cal_ac12[31:16]); ac2 = sx16(cal_ac12[15:0]);
    ac3 = sx16(cal_ac34[31:16]); ac4 = {16'd0, cal_ac34[15:0]};
    ac5 = {16'd0, cal_ac56[31:16]}; ac6 = {16'd0, cal_ac56[15:0]};
    b1 = sx16(cal_b12[31:16]); b2 = sx16(cal_b12[15:0]);
    mc = sx16(cal_mcmd[31:16]); md = sx16(cal_mcmd[15:0]);
    ut = {16'd0, beat.raw_temperature};
    up = {8'd0, beat.raw_pressure} >> (8 - cal_oss);
    r = '0;
    r.divide_error = 1'b1;
    x1 = sra((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = sdiv(mc << 11, den);
    b5 = x1 + x2;
    b6 = b5 - bpc_pkg::B6_OFFSET;
    x1 = sra(b2 * sra(b6 * b6, 12), 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sra(b6 * b6, 12), 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + bpc_pkg::X3_BIAS)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (bpc_pkg::B7_SCALE >> cal_oss);
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * bpc_pkg::P_COEF_SQ, 16);
    x2 = sra(bpc_pkg::P_COEF_LN * p, 16);
    p = p + sra(x1 + x2 + bpc_pkg::P_BIAS, 4);
    t = sra(b5 + 32'd8, 4);
    if ($signed(t) > 32767) r.temperature_tenths = 16'sh7FFF;
    else if ($signed(t) < -32768) r.temperature_tenths = 16'sh8000;
    else r.temperature_tenths = t[15:0];
    r.pressure_pa = p;
    r.divide_error = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && in_ready) begin
      expected_results.push_back(compensate(in_data));
      void'(pending_beats.pop_front());
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= pending_beats[0];
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    bpc_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_data.temperature_tenths !== want.temperature_tenths)
          report_mismatch($sformatf("temperature %0d, want %0d",
                          out_data.temperature_tenths, want.temperature_tenths));
        if (out_data.pressure_pa !== want.pressure_pa)
          report_mismatch($sformatf("pressure %0d, want %0d",
                          out_data.pressure_pa, want.pressure_pa));
        if (out_data.divide_error !== want.divide_error)
          report_mismatch($sformatf("divide error %0b, want %0b",
                          out_data.divide_error, want.divide_error));
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [bpc_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bpc_pkg::CFG_AC1_AC2: cal_ac12 = val;
      bpc_pkg::CFG_AC3_AC4: cal_ac34 = val;
      bpc_pkg::CFG_AC5_AC6: cal_ac56 = val;
      bpc_pkg::CFG_B1_B2:   cal_b12 = val;
      bpc_pkg::CFG_MC_MD:   cal_mcmd = val;
      bpc_pkg::CFG_OSS:     cal_oss = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic load_cal(input int kind);
    if (kind == 0) begin
      write_reg(bpc_pkg::CFG_AC1_AC2, {16'd408, -16'sd72});
      write_reg(bpc_pkg::CFG_AC3_AC4, {-16'sd14383, 16'd32741});
      write_reg(bpc_pkg::CFG_AC5_AC6, {16'd32757, 16'd23153});
      write_reg(bpc_pkg::CFG_B1_B2, {16'd6190, 16'd4});
      write_reg(bpc_pkg::CFG_MC_MD, {-16'sd8711, 16'd2868});
    end else if (kind == 1) begin
      write_reg(bpc_pkg::CFG_AC1_AC2, 32'hFFFF_FFFF);
      write_reg(bpc_pkg::CFG_AC3_AC4, 32'hFFFF_FFFF);
      write_reg(bpc_pkg::CFG_AC5_AC6, 32'hFFFF_FFFF);
      write_reg(bpc_pkg::CFG_B1_B2, 32'hFFFF_FFFF);
      write_reg(bpc_pkg::CFG_MC_MD, 32'h8000_7FFF);
    end else begin
      write_reg(bpc_pkg::CFG_AC1_AC2, $urandom);
      write_reg(bpc_pkg::CFG_AC3_AC4, $urandom);
      write_reg(bpc_pkg::CFG_AC5_AC6, $urandom);
      write_reg(bpc_pkg::CFG_B1_B2, $urandom);
      write_reg(bpc_pkg::CFG_MC_MD, $urandom);
    end
  endtask

  function automatic bpc_pkg::in_beat_t mk(input logic [15:0] t, input logic [23:0] p);
    bpc_pkg::in_beat_t b;
    b.raw_temperature = t;
    b.raw_pressure = p;
    return b;
  endfunction

  task automatic random_beats(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        pending_beats.push_back(mk(16'($urandom), 24'($urandom)));
      else
        pending_beats.push_back(mk(16'($urandom_range(20000, 35000)),
                                   24'($urandom_range(24'h500000, 24'hB00000))));
    end
  endtask

  initial begin
    cal_ac12 = '0; cal_ac34 = '0; cal_ac56 = '0; cal_b12 = '0; cal_mcmd = '0;
    cal_oss = bpc_pkg::OSS_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset calibration: zero divisor on every beat
    pending_beats.push_back(mk(16'h0000, 24'h000000));
    pending_beats.push_back(mk(16'hFFFF, 24'hFFFFFF));
    drain();
    load_cal(0);
    write_reg(bpc_pkg::CFG_OSS, 32'd0);
    pending_beats.push_back(mk(16'd27898, 24'd23843 << 8));
    pending_beats.push_back(mk(16'h0000, 24'h000000));
    pending_beats.push_back(mk(16'hFFFF, 24'hFFFFFF));
    pending_beats.push_back(mk(16'h5555, 24'hAAAAAA));
    pending_beats.push_back(mk(16'hAAAA, 24'h555555));
    pending_beats.push_back(mk(16'd23153, 24'h800000));
    drain();
    // zero temperature divisor: ut = ac6 with md = 0
    write_reg(bpc_pkg::CFG_MC_MD, {-16'sd8711, 16'd0});
    pending_beats.push_back(mk(16'd23153, 24'h123456));
    pending_beats.push_back(mk(16'd30000, 24'h123456));
    drain();
    // zero pressure divisor: ac4 = 0
    write_reg(bpc_pkg::CFG_MC_MD, {-16'sd8711, 16'd2868});
    write_reg(bpc_pkg::CFG_AC3_AC4, {-16'sd14383, 16'd0});
    pending_beats.push_back(mk(16'd27898, 24'h5D2300));
    drain();
    // negative dividend and divisor: mc << 11 = -2^15 over den = -1
    write_reg(bpc_pkg::CFG_AC5_AC6, 32'd0);
    write_reg(bpc_pkg::CFG_MC_MD, {16'hFFF0, 16'hFFFF});
    write_reg(bpc_pkg::CFG_AC3_AC4, {-16'sd14383, 16'd32741});
    pending_beats.push_back(mk(16'd0, 24'hFFFFFF));
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      load_cal(ph % 3);
      write_reg(bpc_pkg::CFG_OSS, 32'(ph % 4));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 66; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 66; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      random_beats(190);
      drain();
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
